// File: rtl/rpnc_pkg.sv
// rpnc_pkg: command, error and microcode definitions for the RPN stack calculator.
// Holds the control-word type, the microprogram table and the command dispatch table.
// No dependencies; used by every module of the block.
package rpnc_pkg;

  localparam int PCW       = 5;
  localparam int ACTW      = 5;
  localparam int CONDW     = 3;
  localparam int DIV_STEPS = 48;
  localparam int CNTW      = 6;
  localparam int FRAC_BITS = 16;

  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_SUB   = 3'd2;
  localparam logic [2:0] CMD_MUL   = 3'd3;
  localparam logic [2:0] CMD_DIV   = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;
  localparam logic [2:0] CMD_DROP  = 3'd6;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_FULL    = 3'd1;
  localparam logic [2:0] ERR_EMPTY   = 3'd2;
  localparam logic [2:0] ERR_DIVZERO = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN = 3'd4;
  localparam logic [2:0] ERR_SAT     = 3'd5;

  localparam logic [ACTW-1:0] ACT_NOP     = 5'd0;
  localparam logic [ACTW-1:0] ACT_POP     = 5'd1;
  localparam logic [ACTW-1:0] ACT_CAPB    = 5'd2;
  localparam logic [ACTW-1:0] ACT_CAPA    = 5'd3;
  localparam logic [ACTW-1:0] ACT_ADD     = 5'd4;
  localparam logic [ACTW-1:0] ACT_SUB     = 5'd5;
  localparam logic [ACTW-1:0] ACT_MUL     = 5'd6;
  localparam logic [ACTW-1:0] ACT_MSHIFT  = 5'd7;
  localparam logic [ACTW-1:0] ACT_DZCHK   = 5'd8;
  localparam logic [ACTW-1:0] ACT_DIVINIT = 5'd9;
  localparam logic [ACTW-1:0] ACT_DIVSTEP = 5'd10;
  localparam logic [ACTW-1:0] ACT_DIVFIN  = 5'd11;
  localparam logic [ACTW-1:0] ACT_CLAMP   = 5'd12;
  localparam logic [ACTW-1:0] ACT_PUSH    = 5'd13;
  localparam logic [ACTW-1:0] ACT_CLEAR   = 5'd14;
  localparam logic [ACTW-1:0] ACT_DROP    = 5'd15;
  localparam logic [ACTW-1:0] ACT_UNK     = 5'd16;
  localparam logic [ACTW-1:0] ACT_RDTOP   = 5'd17;
  localparam logic [ACTW-1:0] ACT_OUT     = 5'd18;

  localparam logic [CONDW-1:0] COND_NEXT     = 3'd0;
  localparam logic [CONDW-1:0] COND_JUMP     = 3'd1;
  localparam logic [CONDW-1:0] COND_DISPATCH = 3'd2;
  localparam logic [CONDW-1:0] COND_BZERO    = 3'd3;
  localparam logic [CONDW-1:0] COND_LOOP     = 3'd4;
  localparam logic [CONDW-1:0] COND_OUT      = 3'd5;

  localparam logic [PCW-1:0] PC_IDLE    = 5'd0;
  localparam logic [PCW-1:0] PC_CLAMP   = 5'd1;
  localparam logic [PCW-1:0] PC_PUSH    = 5'd2;
  localparam logic [PCW-1:0] PC_RDTOP   = 5'd3;
  localparam logic [PCW-1:0] PC_OUT     = 5'd4;
  localparam logic [PCW-1:0] PC_ADD     = 5'd5;
  localparam logic [PCW-1:0] PC_SUB     = 5'd10;
  localparam logic [PCW-1:0] PC_MUL     = 5'd15;
  localparam logic [PCW-1:0] PC_DIV     = 5'd21;
  localparam logic [PCW-1:0] PC_DIVSTEP = 5'd27;
  localparam logic [PCW-1:0] PC_CLEAR   = 5'd29;
  localparam logic [PCW-1:0] PC_DROP    = 5'd30;
  localparam logic [PCW-1:0] PC_UNK     = 5'd31;

  typedef struct packed {
    logic [ACTW-1:0]  act;
    logic [CONDW-1:0] cond;
    logic [PCW-1:0]   target;
  } ctrl_word_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] cmd;
    logic       b_zero;
    logic       cnt_nz;
    logic       out_free;
  } seq_stat_t;

  typedef struct packed {
    logic [ACTW-1:0] act;
    logic            ready;
    logic            accept;
  } seq_ctrl_t;

  function automatic ctrl_word_t cw(input logic [ACTW-1:0] act, input logic [CONDW-1:0] cond,
                                    input logic [PCW-1:0] target);
    ctrl_word_t w;
    w.act    = act;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ctrl_word_t ucode(input logic [PCW-1:0] pc);
    ctrl_word_t w;
    case (pc)
      5'd0:    w = cw(ACT_NOP,     COND_DISPATCH, PC_IDLE);
      5'd1:    w = cw(ACT_CLAMP,   COND_NEXT,     PC_IDLE);
      5'd2:    w = cw(ACT_PUSH,    COND_NEXT,     PC_IDLE);
      5'd3:    w = cw(ACT_RDTOP,   COND_NEXT,     PC_IDLE);
      5'd4:    w = cw(ACT_OUT,     COND_OUT,      PC_IDLE);
      5'd5:    w = cw(ACT_POP,     COND_NEXT,     PC_IDLE);
      5'd6:    w = cw(ACT_CAPB,    COND_NEXT,     PC_IDLE);
      5'd7:    w = cw(ACT_POP,     COND_NEXT,     PC_IDLE);
      5'd8:    w = cw(ACT_CAPA,    COND_NEXT,     PC_IDLE);
      5'd9:    w = cw(ACT_ADD,     COND_JUMP,     PC_CLAMP);
      5'd10:   w = cw(ACT_POP,     COND_NEXT,     PC_IDLE);
      5'd11:   w = cw(ACT_CAPB,    COND_NEXT,     PC_IDLE);
      5'd12:   w = cw(ACT_POP,     COND_NEXT,     PC_IDLE);
      5'd13:   w = cw(ACT_CAPA,    COND_NEXT,     PC_IDLE);
      5'd14:   w = cw(ACT_SUB,     COND_JUMP,     PC_CLAMP);
      5'd15:   w = cw(ACT_POP,     COND_NEXT,     PC_IDLE);
      5'd16:   w = cw(ACT_CAPB,    COND_NEXT,     PC_IDLE);
      5'd17:   w = cw(ACT_POP,     COND_NEXT,     PC_IDLE);
      5'd18:   w = cw(ACT_CAPA,    COND_NEXT,     PC_IDLE);
      5'd19:   w = cw(ACT_MUL,     COND_NEXT,     PC_IDLE);
      5'd20:   w = cw(ACT_MSHIFT,  COND_JUMP,     PC_CLAMP);
      5'd21:   w = cw(ACT_POP,     COND_NEXT,     PC_IDLE);
      5'd22:   w = cw(ACT_CAPB,    COND_NEXT,     PC_IDLE);
      5'd23:   w = cw(ACT_DZCHK,   COND_BZERO,    PC_RDTOP);
      5'd24:   w = cw(ACT_POP,     COND_NEXT,     PC_IDLE);
      5'd25:   w = cw(ACT_CAPA,    COND_NEXT,     PC_IDLE);
      5'd26:   w = cw(ACT_DIVINIT, COND_NEXT,     PC_IDLE);
      5'd27:   w = cw(ACT_DIVSTEP, COND_LOOP,     PC_DIVSTEP);
      5'd28:   w = cw(ACT_DIVFIN,  COND_JUMP,     PC_CLAMP);
      5'd29:   w = cw(ACT_CLEAR,   COND_JUMP,     PC_RDTOP);
      5'd30:   w = cw(ACT_DROP,    COND_JUMP,     PC_RDTOP);
      5'd31:   w = cw(ACT_UNK,     COND_JUMP,     PC_RDTOP);
      default: w = cw(ACT_NOP,     COND_JUMP,     PC_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [PCW-1:0] entry_pc(input logic [2:0] cmd);
    logic [PCW-1:0] pc;
    case (cmd)
      CMD_PUSH:  pc = PC_PUSH;
      CMD_ADD:   pc = PC_ADD;
      CMD_SUB:   pc = PC_SUB;
      CMD_MUL:   pc = PC_MUL;
      CMD_DIV:   pc = PC_DIV;
      CMD_CLEAR: pc = PC_CLEAR;
      CMD_DROP:  pc = PC_DROP;
      default:   pc = PC_UNK;
    endcase
    return pc;
  endfunction

endpackage

// File: rtl/rpn_stack_calculator.sv
// rpn_stack_calculator: postfix stack calculator on signed Q16.16 values.
// Top level with stack memory, datapath and the microcoded sequencer.
// Depends on rpnc_pkg and rpnc_sequencer.
//
// Input words carry one command each: in_tuser selects push, add, subtract,
// multiply, divide, clear or drop (other codes only flag an error), in_tdata
// holds the value to push. Every command returns one output word with the
// bottom entry, the top entry, the depth and an error code.
// A microprogram runs one step a cycle unless held at its output step; one stack
// memory port serves each pop and the final top read. Steps after a word is taken:
//   push: push, top read, output; clear, drop, unknown: the action, top read, output
//   add, subtract: pop and capture b, pop and capture a, operate, clamp, push, top
//   read, output; multiply adds a rescale step after the product
//   divide: pop and capture b, zero check, pop and capture a, set-up, 48 restoring
//   steps (one quotient bit a cycle), sign, clamp, push, top read, output; a zero
//   or missing divisor jumps from the zero check to the top read.
// The next word is taken once the program is back at its idle step; the previous
// result may still wait in the output register. When the receiver stalls, the
// result is held and the program waits at its output step. Reset empties the stack,
// zeroes the bottom entry and drops any pending result; no clearing pass is needed.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand_value
  input  logic [2:0]  in_tuser,   // [2:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [31:0] bottom_value, [63:32] top_value,
                                  // [71:64] depth, [74:72] error_code
);
  import rpnc_pkg::*;

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
  localparam logic signed [63:0] MUL_RND = 64'sd65535;

  logic [31:0] mem [STACK_DEPTH];

  logic [SPW-1:0]     sp_r, sp_nxt;
  logic signed [31:0] a_r, a_nxt;
  logic signed [31:0] b_r, b_nxt;
  logic signed [63:0] res_r, res_nxt;
  logic [2:0]         err_r, err_nxt;
  logic [31:0]        bottom_r, bottom_nxt;
  logic               popok_r, popok_nxt;
  logic [31:0]        rdata_r;
  logic [31:0]        rem_r, rem_nxt;
  logic [47:0]        quo_r, quo_nxt;
  logic [31:0]        dvs_r, dvs_nxt;
  logic               neg_r, neg_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [79:0]        out_data_r, out_data_nxt;

  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [SPW-1:0]     sp_dec;
  logic               out_free;
  logic [31:0]        amag;
  logic [31:0]        bmag;
  logic [32:0]        rshift;
  logic [33:0]        diff;
  logic [63:0]        qext;
  logic [31:0]        top_w;
  logic signed [63:0] prod_w;

  seq_stat_t stat;
  seq_ctrl_t ctrl;

  function automatic logic [2:0] raise(input logic [2:0] cur, input logic [2:0] code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

  assign sp_dec   = sp_r - SPW'(1);
  assign out_free = !out_valid_r || out_tready;
  assign amag     = a_r[31] ? 32'(-a_r) : a_r;
  assign bmag     = b_r[31] ? 32'(-b_r) : b_r;
  assign rshift   = {rem_r, quo_r[47]};
  assign diff     = {1'b0, rshift} - {2'b00, dvs_r};
  assign qext     = {16'h0000, quo_r};
  assign top_w    = (sp_r == '0) ? 32'h0 : rdata_r;
  assign prod_w   = 64'(a_r) * 64'(b_r);

  always_comb begin
    stat.in_valid = in_tvalid;
    stat.cmd      = in_tuser;
    stat.b_zero   = (b_r == 32'sd0);
    stat.cnt_nz   = (cnt_r != '0);
    stat.out_free = out_free;
  end

  rpnc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign in_tready  = ctrl.ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    sp_nxt        = sp_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    bottom_nxt    = bottom_r;
    popok_nxt     = popok_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = sp_r[AW-1:0];
    mem_raddr     = sp_dec[AW-1:0];

    case (ctrl.act)
      ACT_NOP: begin
      end
      ACT_POP: begin
        if (sp_r == '0) begin
          err_nxt   = raise(err_r, ERR_EMPTY);
          popok_nxt = 1'b0;
        end else begin
          mem_re    = 1'b1;
          sp_nxt    = sp_dec;
          popok_nxt = 1'b1;
        end
      end
      ACT_CAPB:    b_nxt = popok_r ? rdata_r : 32'h0;
      ACT_CAPA:    a_nxt = popok_r ? rdata_r : 32'h0;
      ACT_ADD:     res_nxt = {{32{a_r[31]}}, a_r} + {{32{b_r[31]}}, b_r};
      ACT_SUB:     res_nxt = {{32{a_r[31]}}, a_r} - {{32{b_r[31]}}, b_r};
      ACT_MUL:     res_nxt = prod_w;
      ACT_MSHIFT: begin
        if (res_r[63]) begin
          res_nxt = (res_r + MUL_RND) >>> FRAC_BITS;
        end else begin
          res_nxt = res_r >>> FRAC_BITS;
        end
      end
      ACT_DZCHK: begin
        if (b_r == 32'sd0) begin
          err_nxt = raise(err_r, ERR_DIVZERO);
        end
      end
      ACT_DIVINIT: begin
        quo_nxt = {amag, 16'h0000};
        rem_nxt = 32'h0;
        dvs_nxt = bmag;
        neg_nxt = a_r[31] ^ b_r[31];
        cnt_nxt = CNTW'(DIV_STEPS - 1);
      end
      ACT_DIVSTEP: begin
        cnt_nxt = cnt_r - CNTW'(1);
        if (!diff[33]) begin
          rem_nxt = diff[31:0];
          quo_nxt = {quo_r[46:0], 1'b1};
        end else begin
          rem_nxt = rshift[31:0];
          quo_nxt = {quo_r[46:0], 1'b0};
        end
      end
      ACT_DIVFIN:  res_nxt = neg_r ? -$signed(qext) : $signed(qext);
      ACT_CLAMP: begin
        if (res_r > SAT_MAX) begin
          err_nxt = raise(err_r, ERR_SAT);
          res_nxt = SAT_MAX;
        end else if (res_r < SAT_MIN) begin
          err_nxt = raise(err_r, ERR_SAT);
          res_nxt = SAT_MIN;
        end
      end
      ACT_PUSH: begin
        if (sp_r >= SP_FULL) begin
          err_nxt = raise(err_r, ERR_FULL);
        end else begin
          mem_we = 1'b1;
          if (sp_r == '0) begin
            bottom_nxt = res_r[31:0];
          end
          sp_nxt = sp_r + SPW'(1);
        end
      end
      ACT_CLEAR: begin
        sp_nxt     = '0;
        bottom_nxt = 32'h0;
      end
      ACT_DROP: begin
        if (sp_r == '0) begin
          err_nxt = raise(err_r, ERR_EMPTY);
        end else begin
          sp_nxt = sp_dec;
        end
      end
      ACT_UNK:     err_nxt = raise(err_r, ERR_UNKNOWN);
      ACT_RDTOP:   mem_re = (sp_r != '0);
      ACT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b00000, err_r, 8'(sp_r), top_w, bottom_r};
        end
      end
      default: begin
      end
    endcase

    if (ctrl.accept) begin
      res_nxt = {{32{in_tdata[31]}}, in_tdata};
      err_nxt = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= res_r[31:0];
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      bottom_r    <= 32'h0;
      err_r       <= ERR_NONE;
      popok_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r        <= sp_nxt;
      bottom_r    <= bottom_nxt;
      err_r       <= err_nxt;
      popok_r     <= popok_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    res_r      <= res_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/rpnc_sequencer.sv
// rpnc_sequencer: step counter and control-store lookup for the RPN calculator.
// Branches on datapath status and dispatches each new command word.
// Depends on rpnc_pkg.
module rpnc_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rpnc_pkg::seq_stat_t  stat,
  output rpnc_pkg::seq_ctrl_t  ctrl
);
  import rpnc_pkg::*;

  logic [PCW-1:0] pc_r;
  logic [PCW-1:0] pc_nxt;
  ctrl_word_t     word;

  assign word = ucode(pc_r);

  always_comb begin
    ctrl.act    = word.act;
    ctrl.ready  = (word.cond == COND_DISPATCH);
    ctrl.accept = (word.cond == COND_DISPATCH) && stat.in_valid;
  end

  always_comb begin
    pc_nxt = pc_r + 5'd1;
    case (word.cond)
      COND_NEXT:     pc_nxt = pc_r + 5'd1;
      COND_JUMP:     pc_nxt = word.target;
      COND_DISPATCH: pc_nxt = stat.in_valid ? entry_pc(stat.cmd) : pc_r;
      COND_BZERO:    pc_nxt = stat.b_zero ? word.target : pc_r + 5'd1;
      COND_LOOP:     pc_nxt = stat.cnt_nz ? word.target : pc_r + 5'd1;
      COND_OUT:      pc_nxt = stat.out_free ? word.target : pc_r;
      default:       pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: rtl/rpnc_checker.sv
// rpnc_checker: port-level assertions for the RPN stack calculator.
// Bound to rpn_stack_calculator; depends on rpnc_pkg.
module rpnc_checker #(
  parameter int STACK_DEPTH = 128
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);
  import rpnc_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[74:72] <= ERR_SAT)
    else $error("error code out of range");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[71:64] == 8'd0 && STACK_DEPTH < 256
      |-> out_tdata[63:32] == 32'h0)
    else $error("empty stack reports nonzero top");

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[74:72] == ERR_FULL |-> out_tdata[71:64] == 8'(STACK_DEPTH))
    else $error("full error without full depth");

endmodule

bind rpn_stack_calculator rpnc_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rpnc_checker (.*);

// File: verif/tb_top.sv
// tb_top: self-checking stream testbench for the RPN stack calculator.
// Drives command words with random gaps, predicts each result word from a local
// Q16.16 stack model and checks it field by field. Depends on rpnc_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpnc_pkg::*;

  localparam int STACK_ENTRIES = 128;
  localparam logic [2:0] CMD_UNKNOWN = 3'd7;
  localparam int RANDOM_WORDS = 1600;
  localparam int QUIET_TAIL = 200;
  localparam int HOLD_OFF_AFTER = 400;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam longint Q16_MAX = 64'sd2147483647;
  localparam longint Q16_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] operand;
  } cmd_word_t;

  typedef struct packed {
    logic [31:0] bottom;
    logic [31:0] top;
    logic [7:0]  depth;
    logic [2:0]  err;
  } stack_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] operand_value
  logic [2:0]  in_tuser = '0;   // [2:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // [31:0] bottom_value, [63:32] top_value,
                                // [71:64] depth, [74:72] error_code

  rpn_stack_calculator #(.STACK_DEPTH(STACK_ENTRIES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  cmd_word_t   pending_words[$];
  stack_view_t expected_views[$];
  logic [31:0] calc_stack [STACK_ENTRIES];
  int unsigned calc_sp = 0;

  int sent_cnt = 0;
  int acc_cnt = 0;
  int results_seen = 0;
  int fail_cnt = 0;
  int gen_depth = 0;
  int gen_count = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet = 1'b0;
  int cmd_hits [8] = '{default: 0};
  int err_hits [8] = '{default: 0};
  int unsigned cycle_cnt = 0;
  int stall_cycles = 0;
  logic calm;

  assign calm = (cycle_cnt % 1024) < 160;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    fail_cnt++;
  endtask

  function automatic void note_err(inout logic [2:0] err, input logic [2:0] code);
    if (err == ERR_NONE) err = code;
  endfunction

  function automatic longint calc_pop(inout logic [2:0] err);
    if (calc_sp == 0) begin
      note_err(err, ERR_EMPTY);
      return 0;
    end
    calc_sp--;
    return longint'($signed(calc_stack[calc_sp]));
  endfunction

  function automatic void calc_push(input longint v, inout logic [2:0] err);
    if (calc_sp >= STACK_ENTRIES) begin
      note_err(err, ERR_FULL);
    end else begin
      calc_stack[calc_sp] = v[31:0];
      calc_sp++;
    end
  endfunction

  function automatic longint clamp_q16(input longint v, inout logic [2:0] err);
    if (v > Q16_MAX) begin
      note_err(err, ERR_SAT);
      return Q16_MAX;
    end
    if (v < Q16_MIN) begin
      note_err(err, ERR_SAT);
      return Q16_MIN;
    end
    return v;
  endfunction

  function automatic stack_view_t calc_apply(input cmd_word_t w);
    stack_view_t v;
    logic [2:0]  err;
    longint      a;
    longint      b;
    longint      r;
    err = ERR_NONE;
    case (w.cmd)
      CMD_PUSH: calc_push(longint'($signed(w.operand)), err);
      CMD_ADD: begin
        b = calc_pop(err);
        a = calc_pop(err);
        r = clamp_q16(a + b, err);
        calc_push(r, err);
      end
      CMD_SUB: begin
        b = calc_pop(err);
        a = calc_pop(err);
        r = clamp_q16(a - b, err);
        calc_push(r, err);
      end
      CMD_MUL: begin
        b = calc_pop(err);
        a = calc_pop(err);
        r = clamp_q16((a * b) / 65536, err);
        calc_push(r, err);
      end
      CMD_DIV: begin
        b = calc_pop(err);
        if (b != 0) begin
          a = calc_pop(err);
          r = clamp_q16((a * 65536) / b, err);
          calc_push(r, err);
        end else begin
          note_err(err, ERR_DIVZERO);
        end
      end
      CMD_CLEAR: begin
        calc_sp = 0;
        calc_stack[0] = '0;
      end
      CMD_DROP: begin
        if (calc_sp == 0) note_err(err, ERR_EMPTY);
        else calc_sp--;
      end
      default: note_err(err, ERR_UNKNOWN);
    endcase
    v.bottom = calc_stack[0];
    v.top    = (calc_sp == 0) ? 32'h0 : calc_stack[calc_sp - 1];
    v.depth  = calc_sp[7:0];
    v.err    = err;
    return v;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] r;
    case ($urandom_range(0, 7))
      0, 1, 2: r = $urandom;
      3:       r = 32'(($urandom_range(0, 16) - 8) * 65536);
      4:       r = 32'($urandom_range(0, 511)) - 32'd256;
      5: begin
        case ($urandom_range(0, 4))
          0:       r = 32'h7FFF_FFFF;
          1:       r = 32'h8000_0000;
          2:       r = 32'hFFFF_FFFF;
          3:       r = 32'h0000_0001;
          default: r = 32'h0001_0000;
        endcase
      end
      6:       r = '0;
      default: r = 32'($signed($urandom) >>> 12);
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pick_arith();
    case ($urandom_range(0, 3))
      0:       return CMD_ADD;
      1:       return CMD_SUB;
      2:       return CMD_MUL;
      default: return CMD_DIV;
    endcase
  endfunction

  task automatic add_word(input logic [2:0] cmd, input logic [31:0] operand);
    cmd_word_t w;
    w.cmd = cmd;
    w.operand = operand;
    pending_words.push_back(w);
    gen_count++;
    case (cmd)
      CMD_PUSH: if (gen_depth < STACK_ENTRIES) gen_depth++;
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: gen_depth = (gen_depth >= 2) ? gen_depth - 1 : 1;
      CMD_CLEAR: gen_depth = 0;
      CMD_DROP: if (gen_depth > 0) gen_depth--;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int start;
    int phase;
    int r;
    for (int i = 0; i < STACK_ENTRIES; i++) calc_stack[i] = '0;
    calc_sp = 0;

    // empty stack, clear, drop on empty, unknown command
    add_word(CMD_ADD, 32'h0);
    add_word(CMD_CLEAR, $urandom);
    add_word(CMD_DROP, 32'h0);
    add_word(CMD_DIV, 32'h0);
    add_word(CMD_UNKNOWN, 32'hFFFF_FFFF);
    // saturation at both limits, divide by zero
    add_word(CMD_PUSH, 32'h7FFF_FFFF);
    add_word(CMD_PUSH, 32'h7FFF_FFFF);
    add_word(CMD_ADD, 32'h0);
    add_word(CMD_PUSH, 32'h8000_0000);
    add_word(CMD_SUB, 32'h0);
    add_word(CMD_PUSH, 32'h0);
    add_word(CMD_DIV, 32'h0);
    add_word(CMD_PUSH, 32'h8000_0000);
    add_word(CMD_MUL, 32'h0);
    add_word(CMD_PUSH, 32'hFFFF_0000);
    add_word(CMD_DIV, 32'h0);
    // truncation toward zero
    add_word(CMD_PUSH, 32'h0000_0003);
    add_word(CMD_PUSH, 32'hFFFF_FFFF);
    add_word(CMD_MUL, 32'h0);
    add_word(CMD_PUSH, 32'h0001_0000);
    add_word(CMD_PUSH, 32'h0003_0000);
    add_word(CMD_DIV, 32'h0);
    add_word(CMD_DROP, 32'h0);
    add_word(CMD_CLEAR, 32'h0);

    start = gen_count;
    phase = 0;
    while (gen_count - start < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 2 || phase == 5) begin
        repeat (STACK_ENTRIES - gen_depth + $urandom_range(1, 4)) add_word(CMD_PUSH, pick_operand());
        repeat ($urandom_range(2, 8)) add_word(pick_arith(), $urandom);
      end else if (r < 72) begin
        repeat ($urandom_range(4, 16)) begin
          if (gen_depth >= 2 && $urandom_range(0, 99) < 55) add_word(pick_arith(), $urandom);
          else if ($urandom_range(0, 19) == 0) add_word(CMD_DROP, $urandom);
          else add_word(CMD_PUSH, pick_operand());
        end
      end else if (r < 80) begin
        add_word(CMD_CLEAR, $urandom);
      end else begin
        repeat ($urandom_range(1, 6)) add_word(3'($urandom_range(0, 7)), $urandom);
      end
      if (gen_depth > 40 && $urandom_range(0, 3) == 0) add_word(CMD_CLEAR, $urandom);
      phase++;
    end

    while (pending_words.size() != 0 || sent_cnt != acc_cnt) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands: push %0d, add %0d, sub %0d, mul %0d, div %0d, clear %0d,",
             acc_cnt, cmd_hits[CMD_PUSH], cmd_hits[CMD_ADD], cmd_hits[CMD_SUB],
             cmd_hits[CMD_MUL], cmd_hits[CMD_DIV], cmd_hits[CMD_CLEAR]);
    $display("  drop %0d, unknown %0d; errors: full %0d, empty %0d, div0 %0d, sat %0d",
             cmd_hits[CMD_DROP], cmd_hits[CMD_UNKNOWN], err_hits[ERR_FULL],
             err_hits[ERR_EMPTY], err_hits[ERR_DIVZERO], err_hits[ERR_SAT]);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(negedge clk) begin : drive_words
    cmd_word_t w;
    if (rst_n) begin
      quiet <= (pending_words.size() < QUIET_TAIL);
      if (in_tvalid && sent_cnt != acc_cnt) begin
        // hold the offered word until taken
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 3);
        in_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_tuser  <= w.cmd;
        in_tdata  <= w.operand;
        in_tvalid <= 1'b1;
        sent_cnt++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : take_words
    cmd_word_t w;
    if (rst_n && in_tvalid && in_tready) begin
      w.cmd = in_tuser;
      w.operand = in_tdata;
      expected_views.push_back(calc_apply(w));
      cmd_hits[in_tuser]++;
      acc_cnt++;
    end
  end

  always @(negedge clk) begin : pace_results
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
      // stall the receiver long enough for the block to back up
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    stack_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_views.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing pending", out_tdata));
      end else begin
        want = expected_views.pop_front();
        err_hits[want.err]++;
        if (out_tdata[31:0] !== want.bottom)
          report_mismatch($sformatf("word %0d bottom_value %h, want %h",
                                    results_seen, out_tdata[31:0], want.bottom));
        if (out_tdata[63:32] !== want.top)
          report_mismatch($sformatf("word %0d top_value %h, want %h",
                                    results_seen, out_tdata[63:32], want.top));
        if (out_tdata[71:64] !== want.depth)
          report_mismatch($sformatf("word %0d depth %0d, want %0d",
                                    results_seen, out_tdata[71:64], want.depth));
        if (out_tdata[74:72] !== want.err)
          report_mismatch($sformatf("word %0d error_code %0d, want %0d",
                                    results_seen, out_tdata[74:72], want.err));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
